FILE: rtl/world_member_list_manager_assert.svh
// Assertion macros used by the checker of the member list manager.
`ifndef WORLD_MEMBER_LIST_MANAGER_ASSERT_SVH
`define WORLD_MEMBER_LIST_MANAGER_ASSERT_SVH

// Same-cycle implication, muted while reset is asserted.
`define WMLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wmlm: implication check failed");

// Next-cycle implication, muted while reset is asserted.
`define WMLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wmlm: next-cycle check failed");

// Next-cycle implication that also covers reset cycles.
`define WMLM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wmlm: reset check failed");

`endif

FILE: rtl/wmlm_pkg.sv
package wmlm_pkg;

  localparam int DEF_NUM_WORLDS = 128;
  localparam int DEF_NUM_GROUPS = 8;
  localparam int DEF_NUM_USERS  = 65536;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_USER  = 2'd1;
  localparam logic [1:0] ST_BAD_WORLD = 2'd2;
  localparam logic [1:0] ST_NO_USER   = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,   // zero the next entry of each store not yet cleared
    OP_CAP,   // capture the request
    OP_CHK,   // take the table index
    OP_RDU,   // read the member entry
    OP_LAT,   // latch neighbors and list slot
    OP_UNL,   // splice the neighbors together
    OP_CLRU,  // zero the member entry
    OP_SRD,   // read head of the scanned group
    OP_SCK,   // test that head, advance the scan
    OP_PHR,   // read head of the join list
    OP_PHW,   // link member at the head
    OP_PHF,   // finish head insert
    OP_PTR,   // read tail of the join list
    OP_PTW,   // link member at the tail
    OP_PTF    // finish tail insert
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       resp;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       user_bad;
    logic       world_bad;
    logic       mw_zero;
    logic       head_nz;
    logic       scan_last;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

  function automatic int grp_mod(input logic [2:0] g, input int ng);
    int v;
    v = int'(g);
    for (int i = 0; i < 8; i++) begin
      if (v >= ng) begin
        v = v - ng;
      end
    end
    return v;
  endfunction

endpackage

FILE: rtl/wmlm_dp.sv
module wmlm_dp import wmlm_pkg::*; #(
  parameter int NUM_WORLDS = DEF_NUM_WORLDS,
  parameter int NUM_GROUPS = DEF_NUM_GROUPS,
  parameter int NUM_USERS  = DEF_NUM_USERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_user_id,
  input  logic [6:0]  in_world,
  input  logic [2:0]  in_join_group,
  input  logic [2:0]  in_start_group,
  input  logic        out_ready,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_user
);

  localparam int UW    = $clog2(NUM_USERS);
  localparam int NSLOT = NUM_WORLDS * NUM_GROUPS;
  localparam int SW    = $clog2(NSLOT);
  localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int WGW   = 7 + GW;
  localparam int CLR_N = (NUM_USERS > NSLOT) ? NUM_USERS : NSLOT;
  localparam int CW    = $clog2(CLR_N);

  logic [WGW-1:0] mem_wg [NUM_USERS];
  logic [UW-1:0]  mem_pv [NUM_USERS];
  logic [UW-1:0]  mem_nx [NUM_USERS];
  logic [UW-1:0]  mem_hd [NSLOT];
  logic [UW-1:0]  mem_tl [NSLOT];

  logic [1:0]     req_r;
  logic [31:0]    uid_r;
  logic [6:0]     world_r;
  logic [GW-1:0]  jg_r;
  logic [GW-1:0]  g_r;
  logic [GW-1:0]  scnt_r;
  logic [UW-1:0]  u_r, p_r, n_r;
  logic [SW-1:0]  s_r;
  logic [31:0]    base_r;
  logic [31:0]    found_r;
  logic [CW-1:0]  cnt_r;
  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [31:0]    out_found_r;

  logic [WGW-1:0] rd_wg;
  logic [UW-1:0]  rd_pv, rd_nx, rd_hd, rd_tl;

  logic [31:0]    diff;
  logic [SW-1:0]  sj;
  logic           mem_clr, lst_clr;

  logic           wg_we, pv_we, nx_we, hd_we, tl_we, mb_re, hd_re, tl_re;
  logic [UW-1:0]  wg_wa, pv_wa, nx_wa;
  logic [SW-1:0]  hd_wa, tl_wa, hd_ra;
  logic [WGW-1:0] wg_wd;
  logic [UW-1:0]  pv_wd, nx_wd, hd_wd, tl_wd;

  function automatic logic [SW-1:0] slot_of(input logic [6:0] w, input logic [GW-1:0] g);
    return SW'(32'(w) * 32'(NUM_GROUPS) + 32'(g));
  endfunction

  assign diff    = uid_r - base_r;
  assign sj      = slot_of(world_r, jg_r);
  assign mem_clr = 32'(cnt_r) < 32'(NUM_USERS);
  assign lst_clr = 32'(cnt_r) < 32'(NSLOT);

  assign stat.req       = req_r;
  assign stat.user_bad  = (uid_r < base_r) || (diff == '0) || (diff >= 32'(NUM_USERS));
  assign stat.world_bad = (world_r == '0) || (32'(world_r) >= 32'(NUM_WORLDS));
  assign stat.mw_zero   = rd_wg[WGW-1 -: 7] == '0;
  assign stat.head_nz   = rd_hd != '0;
  assign stat.scan_last = scnt_r == GW'(NUM_GROUPS - 1);
  assign stat.clr_last  = cnt_r == CW'(CLR_N - 1);
  assign stat.out_free  = !out_valid_r || out_ready;

  // memory port steering
  always_comb begin
    wg_we = 1'b0; pv_we = 1'b0; nx_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
    mb_re = 1'b0; hd_re = 1'b0; tl_re = 1'b0;
    wg_wa = u_r;  pv_wa = u_r;  nx_wa = u_r;  hd_wa = sj;  tl_wa = sj;  hd_ra = sj;
    wg_wd = '0;   pv_wd = '0;   nx_wd = '0;   hd_wd = u_r; tl_wd = u_r;
    unique case (cmd.op)
      OP_CLR: begin
        wg_we = mem_clr; pv_we = mem_clr; nx_we = mem_clr;
        hd_we = lst_clr; tl_we = lst_clr;
        wg_wa = cnt_r[UW-1:0]; pv_wa = cnt_r[UW-1:0]; nx_wa = cnt_r[UW-1:0];
        hd_wa = cnt_r[SW-1:0]; tl_wa = cnt_r[SW-1:0];
        hd_wd = '0; tl_wd = '0;
      end
      OP_RDU: mb_re = 1'b1;
      OP_UNL: begin
        if (p_r != '0) begin
          nx_we = 1'b1; nx_wa = p_r; nx_wd = n_r;
        end else begin
          hd_we = 1'b1; hd_wa = s_r; hd_wd = n_r;
        end
        if (n_r != '0) begin
          pv_we = 1'b1; pv_wa = n_r; pv_wd = p_r;
        end else begin
          tl_we = 1'b1; tl_wa = s_r; tl_wd = p_r;
        end
      end
      OP_CLRU: begin
        wg_we = 1'b1; pv_we = 1'b1; nx_we = 1'b1;
      end
      OP_SRD: begin
        hd_re = 1'b1; hd_ra = slot_of(world_r, g_r);
      end
      OP_PHR: hd_re = 1'b1;
      OP_PHW: begin
        wg_we = 1'b1; wg_wd = {world_r, jg_r};
        nx_we = 1'b1; nx_wd = rd_hd;
        hd_we = 1'b1;
        if (rd_hd != '0) begin
          pv_we = 1'b1; pv_wa = rd_hd; pv_wd = u_r;
        end else begin
          tl_we = 1'b1;
        end
      end
      OP_PHF: pv_we = 1'b1;
      OP_PTR: tl_re = 1'b1;
      OP_PTW: begin
        wg_we = 1'b1; wg_wd = {world_r, jg_r};
        pv_we = 1'b1; pv_wd = rd_tl;
        tl_we = 1'b1;
        if (rd_tl != '0) begin
          nx_we = 1'b1; nx_wa = rd_tl; nx_wd = u_r;
        end else begin
          hd_we = 1'b1;
        end
      end
      OP_PTF: nx_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wg_we) mem_wg[wg_wa] <= wg_wd;
    if (mb_re) rd_wg <= mem_wg[u_r];
  end

  always_ff @(posedge clk) begin
    if (pv_we) mem_pv[pv_wa] <= pv_wd;
    if (mb_re) rd_pv <= mem_pv[u_r];
  end

  always_ff @(posedge clk) begin
    if (nx_we) mem_nx[nx_wa] <= nx_wd;
    if (mb_re) rd_nx <= mem_nx[u_r];
  end

  always_ff @(posedge clk) begin
    if (hd_we) mem_hd[hd_wa] <= hd_wd;
    if (hd_re) rd_hd <= mem_hd[hd_ra];
  end

  always_ff @(posedge clk) begin
    if (tl_we) mem_tl[tl_wa] <= tl_wd;
    if (tl_re) rd_tl <= mem_tl[sj];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) base_r <= cfg_wr_data;
      if (cmd.op == OP_CLR) cnt_r <= cnt_r + 1'b1;
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAP) begin
      req_r   <= in_req_type;
      uid_r   <= in_user_id;
      world_r <= in_world;
      jg_r    <= GW'(grp_mod(in_join_group, NUM_GROUPS));
      g_r     <= GW'(grp_mod(in_start_group, NUM_GROUPS));
      scnt_r  <= '0;
      found_r <= '0;
    end
    if (cmd.op == OP_CHK) u_r <= diff[UW-1:0];
    if (cmd.op == OP_LAT) begin
      p_r <= rd_pv;
      n_r <= rd_nx;
      s_r <= slot_of(rd_wg[WGW-1 -: 7], rd_wg[GW-1:0]);
    end
    if (cmd.op == OP_SCK) begin
      if (rd_hd != '0) begin
        u_r     <= rd_hd;
        found_r <= 32'(rd_hd) + base_r;
      end else begin
        g_r    <= (g_r == GW'(NUM_GROUPS - 1)) ? '0 : g_r + 1'b1;
        scnt_r <= scnt_r + 1'b1;
      end
    end
    if (cmd.resp) begin
      out_status_r <= cmd.status;
      out_found_r  <= found_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found_user = out_found_r;

endmodule

FILE: rtl/wmlm_ctrl.sv
module wmlm_ctrl import wmlm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_RDU  = 4'd3;
  localparam logic [3:0] S_LAT  = 4'd4;
  localparam logic [3:0] S_UNL  = 4'd5;
  localparam logic [3:0] S_CLRU = 4'd6;
  localparam logic [3:0] S_SRD  = 4'd7;
  localparam logic [3:0] S_SCK  = 4'd8;
  localparam logic [3:0] S_PHR  = 4'd9;
  localparam logic [3:0] S_PHW  = 4'd10;
  localparam logic [3:0] S_PHF  = 4'd11;
  localparam logic [3:0] S_PTR  = 4'd12;
  localparam logic [3:0] S_PTW  = 4'd13;
  localparam logic [3:0] S_PTF  = 4'd14;
  localparam logic [3:0] S_RESP = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    cmd.op     = OP_NOP;
    cmd.resp   = 1'b0;
    cmd.status = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAP;
          state_nxt = S_CHK;
        end
      end
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_CHK: begin
        cmd.op = OP_CHK;
        st_nxt = ST_OK;
        priority if (stat.req == REQ_GET) begin
          if (stat.world_bad) begin
            st_nxt = ST_BAD_WORLD; state_nxt = S_RESP;
          end else begin
            state_nxt = S_SRD;
          end
        end else if (stat.req == REQ_SET || stat.req == REQ_REMOVE) begin
          if (stat.user_bad) begin
            st_nxt = ST_BAD_USER; state_nxt = S_RESP;
          end else if (stat.req == REQ_SET && stat.world_bad) begin
            st_nxt = ST_BAD_WORLD; state_nxt = S_RESP;
          end else begin
            state_nxt = S_RDU;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RDU: begin
        cmd.op    = OP_RDU;
        state_nxt = S_LAT;
      end
      S_LAT: begin
        cmd.op = OP_LAT;
        priority if (!stat.mw_zero) state_nxt = S_UNL;
        else if (stat.req == REQ_SET) state_nxt = S_PHR;
        else state_nxt = S_RESP;
      end
      S_UNL: begin
        cmd.op = OP_UNL;
        priority if (stat.req == REQ_SET) state_nxt = S_PHR;
        else if (stat.req == REQ_GET) state_nxt = S_PTR;
        else state_nxt = S_CLRU;
      end
      S_CLRU: begin
        cmd.op = OP_CLRU; state_nxt = S_RESP;
      end
      S_SRD: begin
        cmd.op = OP_SRD; state_nxt = S_SCK;
      end
      S_SCK: begin
        cmd.op = OP_SCK;
        priority if (stat.head_nz) state_nxt = S_RDU;
        else if (stat.scan_last) begin
          st_nxt = ST_NO_USER; state_nxt = S_RESP;
        end else state_nxt = S_SRD;
      end
      S_PHR: begin cmd.op = OP_PHR; state_nxt = S_PHW; end
      S_PHW: begin cmd.op = OP_PHW; state_nxt = S_PHF; end
      S_PHF: begin cmd.op = OP_PHF; state_nxt = S_RESP; end
      S_PTR: begin cmd.op = OP_PTR; state_nxt = S_PTW; end
      S_PTW: begin cmd.op = OP_PTW; state_nxt = S_PTF; end
      S_PTF: begin cmd.op = OP_PTF; state_nxt = S_RESP; end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

FILE: rtl/world_member_list_manager.sv
// Channel | Ports                                   | Accepted when
// --------+-----------------------------------------+--------------------------
// in      | in_valid/in_ready, in_req_type..group   | in_valid && in_ready
// out     | out_valid/out_ready, out_status, found  | out_valid && out_ready
// cfg     | cfg_wr_en, cfg_wr_data (uid_base)       | cfg_wr_en
//
// One item at a time; each list step is a read or write of single-port memories.
// A get scans the groups from its start group, at most NUM_GROUPS of them.
// After reset a clearing pass over max(NUM_USERS, NUM_WORLDS*NUM_GROUPS) entries
// zeroes all stores; in_ready stays low, cfg writes are taken throughout.
// The result register frees the core, so a new item is taken while out stalls.
module world_member_list_manager import wmlm_pkg::*; #(
  parameter int NUM_WORLDS = DEF_NUM_WORLDS,
  parameter int NUM_GROUPS = DEF_NUM_GROUPS,
  parameter int NUM_USERS  = DEF_NUM_USERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_user_id,
  input  logic [6:0]  in_world,
  input  logic [2:0]  in_join_group,
  input  logic [2:0]  in_start_group,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_user
);

  // command from the sequencer, status back from the list datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  wmlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // holds the link memories, request registers and the result register
  wmlm_dp #(
    .NUM_WORLDS (NUM_WORLDS),
    .NUM_GROUPS (NUM_GROUPS),
    .NUM_USERS  (NUM_USERS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_req_type    (in_req_type),
    .in_user_id     (in_user_id),
    .in_world       (in_world),
    .in_join_group  (in_join_group),
    .in_start_group (in_start_group),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found_user (out_found_user)
  );

endmodule

FILE: rtl/wmlm_chk.sv
`include "world_member_list_manager_assert.svh"

module wmlm_chk import wmlm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [31:0] cfg_wr_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic [31:0] in_user_id,
  input logic [6:0]  in_world,
  input logic [2:0]  in_join_group,
  input logic [2:0]  in_start_group,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_found_user
);

  `WMLM_ASSERT_IMP(a_found_only_ok, out_valid && out_status != ST_OK, out_found_user == '0)
  `WMLM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found_user))
  `WMLM_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
  `WMLM_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid && !in_ready)

endmodule

bind world_member_list_manager wmlm_chk u_wmlm_chk (.*);
